FILE: design/qlh_pkg.sv
// Shared types, constants and helper functions for the quad-lane hash block.
// No dependencies; imported by qlh_ctrl, qlh_dp and quad_lane_hash64.
package qlh_pkg;

	localparam int LEN_BITS = 32;

	localparam logic [63:0] K0 = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] K1 = 64'h85EBCA77C2B2AE3D;
	localparam logic [63:0] K2 = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] K3 = 64'h94D049BB133111EB;

	typedef enum logic [2:0] {
		SRC_LEN,
		SRC_BASE,
		SRC_ABS,
		SRC_H0,
		SRC_G0,
		SRC_HG,
		SRC_FIN
	} src_t;

	typedef enum logic [1:0] {
		DST_T,
		DST_G,
		DST_LANE
	} dst_t;

	typedef struct packed {
		logic       load;
		logic       first;
		logic       mul;
		logic [1:0] step;
		src_t       src;
		logic [1:0] kidx;
		dst_t       dst;
		logic [1:0] lane;
		logic [1:0] widx;
		logic       tail;
		logic [1:0] shsel;
		logic       len_sub;
		logic       len_clr;
		logic       hash_ld;
	} cmd_t;

	typedef struct packed {
		logic       len_ge32;
		logic [1:0] full;
		logic       tb_nz;
	} sts_t;

	function automatic logic [63:0] kval(input logic [1:0] idx);
		case (idx)
			2'd0: return K0;
			2'd1: return K1;
			2'd2: return K2;
			default: return K3;
		endcase
	endfunction

	function automatic logic [63:0] lane_rotl(input logic [63:0] v, input logic [1:0] lane);
		case (lane)
			2'd0: return {v[40:0], v[63:41]};
			2'd1: return {v[16:0], v[63:17]};
			2'd2: return {v[50:0], v[63:51]};
			default: return {v[26:0], v[63:27]};
		endcase
	endfunction

	function automatic logic [63:0] fin_xs(input logic [63:0] v, input logic [1:0] sel);
		case (sel)
			2'd0: return v ^ (v >> 17);
			2'd1: return v ^ (v >> 31);
			2'd2: return v ^ (v >> 23);
			default: return v ^ (v >> 41);
		endcase
	endfunction

endpackage

FILE: design/qlh_dp.sv
// Datapath: chunk words, lane accumulators, length count and a shared
// 32x32 multiplier that builds each 64-bit multiply from partial products. Uses qlh_pkg.
module qlh_dp
	import qlh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [63:0] word_a,
	input  logic [63:0] word_b,
	input  logic [63:0] word_c,
	input  logic [63:0] word_d,
	input  logic [63:0] seed_value,
	input  logic [31:0] msg_length,
	output logic [63:0] hash_value
);

	logic [63:0]         w_q [4];
	logic [63:0]         lane_q [4];
	logic [63:0]         seed_q;
	logic [63:0]         t_q;
	logic [63:0]         g_q;
	logic [63:0]         mx_q;
	logic [63:0]         acc_q;
	logic [63:0]         hash_q;
	logic [LEN_BITS-1:0] len_q;
	logic [63:0]         len_ext;
	logic [63:0]         word;
	logic [63:0]         mask;
	logic [63:0]         src;
	logic [63:0]         k;
	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic [63:0]         prod;
	logic [63:0]         res;

	assign len_ext = {32'b0, msg_length};
	assign k       = kval(cmd.kidx);

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			mask[8*j +: 8] = (3'(j) < len_q[2:0]) ? 8'hFF : 8'h00;
		end
		word = w_q[cmd.widx];
		if (cmd.tail) begin
			word = word & mask;
		end
		case (cmd.src)
			SRC_LEN:  src = 64'(len_q);
			SRC_BASE: src = seed_q ^ t_q;
			SRC_ABS:  src = lane_q[cmd.lane] ^ lane_rotl(word, cmd.lane);
			SRC_H0:   src = lane_q[0] ^ lane_q[1];
			SRC_G0:   src = lane_q[2] ^ lane_q[3];
			SRC_HG:   src = t_q ^ g_q;
			SRC_FIN:  src = fin_xs(t_q, cmd.shsel);
			default:  src = '0;
		endcase
	end

	always_comb begin
		case (cmd.step)
			2'd0: begin
				mul_a = src[31:0];
				mul_b = k[31:0];
			end
			2'd1: begin
				mul_a = mx_q[31:0];
				mul_b = k[63:32];
			end
			default: begin
				mul_a = mx_q[63:32];
				mul_b = k[31:0];
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign res  = acc_q + {prod[31:0], 32'b0};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q[0] <= word_a;
			w_q[1] <= word_b;
			w_q[2] <= word_c;
			w_q[3] <= word_d;
			if (cmd.first) begin
				seed_q <= seed_value;
			end
		end
		if (cmd.mul) begin
			case (cmd.step)
				2'd0: begin
					mx_q  <= src;
					acc_q <= prod;
				end
				2'd1: begin
					acc_q <= res;
				end
				default: begin
					case (cmd.dst)
						DST_T:    t_q <= res;
						DST_G:    g_q <= res;
						default:  lane_q[cmd.lane] <= res;
					endcase
				end
			endcase
		end
		if (cmd.hash_ld) begin
			hash_q <= t_q ^ (t_q >> 29);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.load && cmd.first) begin
			len_q <= len_ext[LEN_BITS-1:0];
		end else if (cmd.len_sub) begin
			len_q <= len_q - LEN_BITS'(32);
		end else if (cmd.len_clr) begin
			len_q <= '0;
		end
	end

	assign sts.len_ge32 = (len_q >= LEN_BITS'(32));
	assign sts.full     = len_q[4:3];
	assign sts.tb_nz    = |len_q[2:0];
	assign hash_value   = hash_q;

endmodule

FILE: design/qlh_ctrl.sv
// Controller: sequences seeding, absorption, finalisation and the output
// transaction through commands to qlh_dp. Uses qlh_pkg.
module qlh_ctrl
	import qlh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic first_chunk,
	input  logic last_chunk,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN,
		S_BASE,
		S_FULL,
		S_PART,
		S_TAIL,
		S_FIN,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [1:0] step_q;
	logic [1:0] cnt_q;
	logic [2:0] fin_q;
	logic       last_q;
	logic       in_msg_q;
	logic       out_valid_q;
	logic       out_free;
	logic       step_end;
	logic       part_end;

	function automatic state_t dispatch(input sts_t s, input logic last);
		if (s.len_ge32) begin
			return S_FULL;
		end else if (s.full != 2'd0) begin
			return S_PART;
		end else if (s.tb_nz) begin
			return S_TAIL;
		end else if (last) begin
			return S_FIN;
		end
		return S_IDLE;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign step_end  = (step_q == 2'd2);
	assign part_end  = ((cnt_q + 2'd1) == sts.full);

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.first = first_chunk;
		cmd.step  = step_q;
		cmd.src   = SRC_LEN;
		cmd.dst   = DST_T;
		case (state_q)
			S_LEN: begin
				cmd.mul = 1'b1;
			end
			S_BASE: begin
				cmd.mul  = 1'b1;
				cmd.src  = SRC_BASE;
				cmd.kidx = cnt_q;
				cmd.dst  = DST_LANE;
				cmd.lane = cnt_q;
			end
			S_FULL: begin
				cmd.mul     = 1'b1;
				cmd.src     = SRC_ABS;
				cmd.dst     = DST_LANE;
				cmd.lane    = cnt_q;
				cmd.widx    = cnt_q;
				cmd.len_sub = step_end && (cnt_q == 2'd3);
			end
			S_PART: begin
				cmd.mul     = 1'b1;
				cmd.src     = SRC_ABS;
				cmd.dst     = DST_LANE;
				cmd.widx    = cnt_q;
				cmd.len_clr = step_end && part_end && !sts.tb_nz;
			end
			S_TAIL: begin
				cmd.mul     = 1'b1;
				cmd.src     = SRC_ABS;
				cmd.dst     = DST_LANE;
				cmd.widx    = sts.full;
				cmd.tail    = 1'b1;
				cmd.len_clr = step_end;
			end
			S_FIN: begin
				cmd.mul   = 1'b1;
				cmd.shsel = 2'(fin_q - 3'd3);
				case (fin_q)
					3'd0: cmd.src = SRC_H0;
					3'd1: begin
						cmd.src = SRC_G0;
						cmd.dst = DST_G;
					end
					3'd2: cmd.src = SRC_HG;
					default: cmd.src = SRC_FIN;
				endcase
				case (fin_q)
					3'd3: cmd.kidx = 2'd1;
					3'd4: cmd.kidx = 2'd2;
					3'd6: cmd.kidx = 2'd3;
					default: cmd.kidx = 2'd0;
				endcase
			end
			S_OUT: begin
				cmd.hash_ld = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			cnt_q       <= '0;
			fin_q       <= '0;
			last_q      <= 1'b0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					cnt_q  <= '0;
					fin_q  <= '0;
					if (in_valid) begin
						last_q <= last_chunk;
						if (first_chunk) begin
							in_msg_q <= 1'b1;
							state_q  <= S_LEN;
						end else if (in_msg_q) begin
							state_q <= dispatch(sts, last_chunk);
						end
					end
				end
				S_LEN, S_BASE, S_FULL, S_PART, S_TAIL, S_FIN: begin
					if (!step_end) begin
						step_q <= step_q + 2'd1;
					end else begin
						step_q <= '0;
						case (state_q)
							S_LEN: begin
								state_q <= S_BASE;
							end
							S_BASE: begin
								cnt_q <= cnt_q + 2'd1;
								if (cnt_q == 2'd3) begin
									state_q <= dispatch(sts, last_q);
								end
							end
							S_FULL: begin
								cnt_q <= cnt_q + 2'd1;
								if (cnt_q == 2'd3) begin
									state_q <= last_q ? S_FIN : S_IDLE;
								end
							end
							S_PART: begin
								if (part_end) begin
									cnt_q <= '0;
									if (sts.tb_nz) begin
										state_q <= S_TAIL;
									end else begin
										state_q <= last_q ? S_FIN : S_IDLE;
									end
								end else begin
									cnt_q <= cnt_q + 2'd1;
								end
							end
							S_TAIL: begin
								state_q <= last_q ? S_FIN : S_IDLE;
							end
							default: begin
								fin_q <= fin_q + 3'd1;
								if (fin_q == 3'd6) begin
									state_q <= S_OUT;
								end
							end
						endcase
					end
				end
				S_OUT: begin
					if (out_free) begin
						in_msg_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_step_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != 2'd0 |-> (state_q != S_IDLE && state_q != S_OUT))
		else $error("multiply step outside a multiply state");

	a_sub_needs_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.len_sub |-> sts.len_ge32)
		else $error("length decrement below one chunk");

	a_tail_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAIL |-> sts.tb_nz)
		else $error("tail absorb with no tail bytes");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

endmodule

FILE: design/quad_lane_hash64.sv
// Top level of the quad-lane multiply-rotate hash: joins qlh_ctrl and qlh_dp.
// Depends on qlh_pkg, qlh_ctrl and qlh_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | word_a..word_d, seed_value, msg_length,
//          |                      | first_chunk, last_chunk
//  out     | out_valid / out_stall| hash_value
//
// Each 64x64 multiply runs on one shared 32x32 multiplier, so a full chunk costs
// a load and one multiply per lane; a first item adds the seeding multiplies, a
// short chunk one per word absorbed, a last item the finaliser and output step.
// arst_n clears the controller and length count; the lanes need no reset.
// A held result does not block the next input transaction, only the next hash.
module quad_lane_hash64
	import qlh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] word_a,
	input  logic [63:0] word_b,
	input  logic [63:0] word_c,
	input  logic [63:0] word_d,
	input  logic [63:0] seed_value,
	input  logic [31:0] msg_length,
	input  logic        first_chunk,
	input  logic        last_chunk,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	cmd_t cmd;
	sts_t sts;

	qlh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.first_chunk (first_chunk),
		.last_chunk  (last_chunk),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	qlh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c),
		.word_d     (word_d),
		.seed_value (seed_value),
		.msg_length (msg_length),
		.hash_value (hash_value)
	);

endmodule
